[hw/rtl/sfa_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package sfa_pkg;

    localparam int GRID_MAX    = 7;
    localparam int GRID_SIDE   = 2 * GRID_MAX + 1;
    localparam int STORE_DEPTH = GRID_SIDE * GRID_SIDE * GRID_SIDE;

    localparam int IDX_W      = 12;
    localparam int N_W        = 3;
    localparam int CNT_W      = $clog2(GRID_SIDE);
    localparam int SUM_W      = 40;
    localparam int DISP_W     = 24;
    localparam int STEP_W     = 20;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;
    localparam int PROD_W     = STEP_W + 1 + DISP_W;
    localparam int MAG_W      = PROD_W - 1;
    localparam int PH_W       = 35;
    localparam int ANG_W      = 19;
    localparam int XY_W       = 18;
    localparam int Z_W        = 19;
    localparam int TERM_W     = 17;
    localparam int CORDIC_N   = 16;
    localparam int RED_TOP    = 8;
    localparam int RED_W      = 4;

    localparam logic [PH_W-1:0]   TWO_PI_Q32  = 35'd26986075409;
    localparam logic [ANG_W-1:0]  TWO_PI_Q16  = 19'd411775;
    localparam logic [ANG_W-1:0]  PI_Q16      = 19'd205887;
    localparam logic [ANG_W-1:0]  HALF_PI_Q16 = 19'd102944;
    localparam logic signed [XY_W-1:0] CORDIC_K = 18'sd19899;
    localparam logic [14:0]       COS_MAX     = 15'd32767;

    typedef enum logic [1:0] {
        REQ_ACC   = 2'd0,
        REQ_READ  = 2'd1,
        REQ_CLEAR = 2'd2,
        REQ_NONE  = 2'd3
    } t_req;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GRID_HALF = 2'd0,
        CFG_STEP_GX   = 2'd1,
        CFG_STEP_GY   = 2'd2,
        CFG_STEP_GZ   = 2'd3
    } t_cfg;

    // point tag carried alongside the cosine pipeline
    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic             dbl;
    } t_tag;

    function automatic logic [Z_W-1:0] atan_q16(input int i);
        logic [Z_W-1:0] v;
        case (i)
            0:       v = 19'd51472;
            1:       v = 19'd30386;
            2:       v = 19'd16055;
            3:       v = 19'd8150;
            4:       v = 19'd4091;
            5:       v = 19'd2047;
            6:       v = 19'd1024;
            7:       v = 19'd512;
            8:       v = 19'd256;
            9:       v = 19'd128;
            10:      v = 19'd64;
            11:      v = 19'd32;
            12:      v = 19'd16;
            13:      v = 19'd8;
            14:      v = 19'd4;
            default: v = 19'd2;
        endcase
        return v;
    endfunction

    // (2n+1)^3, points in the grid
    function automatic logic [IDX_W:0] grid_count(input logic [N_W-1:0] n);
        int s;
        s = 2 * int'(n) + 1;
        return (IDX_W+1)'(s * s * s);
    endfunction

    // flat index of (0,-n,-n)
    function automatic logic [IDX_W-1:0] plane_base(input logic [N_W-1:0] n);
        int s;
        s = 2 * int'(n) + 1;
        return IDX_W'(int'(n) * s * s);
    endfunction

    function automatic logic [PH_W-1:0] mod_add(input logic [PH_W-1:0] a,
                                                 input logic [PH_W-1:0] b);
        logic [PH_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, TWO_PI_Q32}) begin
            s = s - {1'b0, TWO_PI_Q32};
        end
        return s[PH_W-1:0];
    endfunction

    function automatic logic [PH_W-1:0] mod_sub(input logic [PH_W-1:0] a,
                                                 input logic [PH_W-1:0] b);
        logic [PH_W-1:0] d;
        if (a >= b) begin
            d = a - b;
        end else begin
            d = a + (TWO_PI_Q32 - b);
        end
        return d;
    endfunction

endpackage
`default_nettype wire

[hw/rtl/sfa_req_if.sv]
`timescale 1ns / 1ps
`default_nettype none
interface sfa_req_if;
    logic                                  valid;
    logic                                  ready;
    logic [1:0]                            req_type;
    logic signed [sfa_pkg::DISP_W-1:0]     disp_x;
    logic signed [sfa_pkg::DISP_W-1:0]     disp_y;
    logic signed [sfa_pkg::DISP_W-1:0]     disp_z;
    logic [sfa_pkg::IDX_W-1:0]             point_index;

    modport source (output valid, req_type, disp_x, disp_y, disp_z, point_index,
                    input ready);
    modport sink (input valid, req_type, disp_x, disp_y, disp_z, point_index,
                  output ready);
endinterface
`default_nettype wire

[hw/rtl/sfa_rsp_if.sv]
`timescale 1ns / 1ps
`default_nettype none
interface sfa_rsp_if;
    logic                              valid;
    logic                              ready;
    logic [sfa_pkg::IDX_W-1:0]         read_index;
    logic signed [sfa_pkg::SUM_W-1:0]  phase_sum;

    modport source (output valid, read_index, phase_sum, input ready);
    modport sink (input valid, read_index, phase_sum, output ready);
endinterface
`default_nettype wire

[hw/rtl/sfa_cordic.sv]
`timescale 1ns / 1ps
`default_nettype none
module sfa_cordic (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_vld,
    input  wire logic [sfa_pkg::PH_W-1:0]          i_phase,
    input  wire sfa_pkg::t_tag                     i_tag,
    output logic                                   o_vld,
    output sfa_pkg::t_tag                          o_tag,
    output logic signed [sfa_pkg::TERM_W-1:0]      o_term,
    output logic                                   o_busy
);
    import sfa_pkg::*;

    logic                     r_vld [CORDIC_N+1];
    logic signed [XY_W-1:0]   r_x   [CORDIC_N+1];
    logic signed [XY_W-1:0]   r_y   [CORDIC_N+1];
    logic signed [Z_W-1:0]    r_z   [CORDIC_N+1];
    logic                     r_neg [CORDIC_N+1];
    t_tag                     r_tag [CORDIC_N+1];

    logic [ANG_W-1:0] ang_raw;
    logic [ANG_W-1:0] ang_a;
    logic [ANG_W-1:0] ang_b;
    logic             fold_neg;
    logic [CORDIC_N:0] vld_vec;

    // fold into the first quadrant
    always_comb begin
        ang_raw = i_phase[PH_W-1 -: ANG_W];
        ang_a   = (ang_raw > PI_Q16) ? (TWO_PI_Q16 - ang_raw) : ang_raw;
        fold_neg = (ang_a > HALF_PI_Q16);
        ang_b   = fold_neg ? (PI_Q16 - ang_a) : ang_a;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= i_vld;
        end
        r_x[0]   <= CORDIC_K;
        r_y[0]   <= '0;
        r_z[0]   <= $signed(ang_b);
        r_neg[0] <= fold_neg;
        r_tag[0] <= i_tag;
    end

    for (genvar k = 0; k < CORDIC_N; k++) begin : g_iter
        logic signed [XY_W-1:0] xs;
        logic signed [XY_W-1:0] ys;
        logic signed [Z_W-1:0]  at;
        assign xs = r_x[k] >>> k;
        assign ys = r_y[k] >>> k;
        assign at = $signed(atan_q16(k));

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else begin
                r_vld[k+1] <= r_vld[k];
            end
            if (!r_z[k][Z_W-1]) begin
                r_x[k+1] <= r_x[k] - ys;
                r_y[k+1] <= r_y[k] + xs;
                r_z[k+1] <= r_z[k] - at;
            end else begin
                r_x[k+1] <= r_x[k] + ys;
                r_y[k+1] <= r_y[k] - xs;
                r_z[k+1] <= r_z[k] + at;
            end
            r_neg[k+1] <= r_neg[k];
            r_tag[k+1] <= r_tag[k];
        end
    end

    // clamp, weight and sign
    logic [14:0]             cos_c;
    logic [TERM_W-2:0]       mag;
    logic signed [TERM_W-1:0] term;

    always_comb begin
        if (r_x[CORDIC_N] < 0) begin
            cos_c = '0;
        end else if (r_x[CORDIC_N] > $signed({3'b000, COS_MAX})) begin
            cos_c = COS_MAX;
        end else begin
            cos_c = r_x[CORDIC_N][14:0];
        end
        mag  = r_tag[CORDIC_N].dbl ? {cos_c, 1'b0} : {1'b0, cos_c};
        term = r_neg[CORDIC_N] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_vld <= 1'b0;
        end else begin
            o_vld <= r_vld[CORDIC_N];
        end
        o_term <= term;
        o_tag  <= r_tag[CORDIC_N];
    end

    for (genvar k = 0; k <= CORDIC_N; k++) begin : g_busy
        assign vld_vec[k] = r_vld[k];
    end

    assign o_busy = (|vld_vec) | o_vld;

endmodule
`default_nettype wire

[hw/rtl/structure_factor_accumulator_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// Accumulate: one grid point per cycle through the 16-stage CORDIC, with a setup state before
//   each plane (ST_PLANE) and before each row (ST_ROW).
// Read: result register loads in ST_RDOUT, the state after the transfer; input waits while a result is held.
// Clear: one store entry per cycle, over all 3375 entries of the sum store.
// Reset (synchronous, active low) sets the registers to their defaults and then runs a
//   clearing pass over all 3375 entries of the sum store; no item is taken until it ends.
module structure_factor_accumulator_core (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [sfa_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire logic [sfa_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    sfa_req_if.sink                                 i_req,
    sfa_rsp_if.source                               o_rsp
);
    import sfa_pkg::*;

    typedef enum logic [10:0] {
        ST_CLR   = 11'b000_0000_0001,
        ST_IDLE  = 11'b000_0000_0010,
        ST_RDOUT = 11'b000_0000_0100,
        ST_MUL   = 11'b000_0000_1000,
        ST_RED   = 11'b000_0001_0000,
        ST_FIX   = 11'b000_0010_0000,
        ST_NEG   = 11'b000_0100_0000,
        ST_PLANE = 11'b000_1000_0000,
        ST_ROW   = 11'b001_0000_0000,
        ST_EMIT  = 11'b010_0000_0000,
        ST_DRAIN = 11'b100_0000_0000
    } t_state;

    t_state r_state;

    // configuration registers
    logic [N_W-1:0]    r_grid_half;
    logic [STEP_W-1:0] r_step_gx;
    logic [STEP_W-1:0] r_step_gy;
    logic [STEP_W-1:0] r_step_gz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_half <= N_W'(1);
            r_step_gx   <= STEP_W'(65536);
            r_step_gy   <= STEP_W'(65536);
            r_step_gz   <= STEP_W'(65536);
        end else if (i_cfg_we) begin
            case (t_cfg'(i_cfg_idx))
                CFG_GRID_HALF: r_grid_half <= i_cfg_data[N_W-1:0];
                CFG_STEP_GX:   r_step_gx   <= i_cfg_data[STEP_W-1:0];
                CFG_STEP_GY:   r_step_gy   <= i_cfg_data[STEP_W-1:0];
                CFG_STEP_GZ:   r_step_gz   <= i_cfg_data[STEP_W-1:0];
                default:       r_grid_half <= r_grid_half;
            endcase
        end
    end

    // effective grid half: zero acts as one, capped at the store size
    logic [N_W-1:0]   eff_n;
    logic [CNT_W-1:0] side_m1;

    always_comb begin
        if (r_grid_half == '0) begin
            eff_n = N_W'(1);
        end else if (int'(r_grid_half) > GRID_MAX) begin
            eff_n = N_W'(GRID_MAX);
        end else begin
            eff_n = r_grid_half;
        end
        side_m1 = CNT_W'({eff_n, 1'b0});
    end

    // item capture
    logic [DISP_W-1:0] r_dx;
    logic [DISP_W-1:0] r_dy;
    logic [DISP_W-1:0] r_dz;
    logic              req_xfer;

    assign i_req.ready = (r_state == ST_IDLE) && (!o_rsp.valid || o_rsp.ready);
    assign req_xfer    = i_req.valid && i_req.ready;

    // per-item phase increments, reduced modulo 2*pi (Q.32)
    logic [1:0]        r_ax;
    logic [MAG_W-1:0]  r_mag;
    logic              r_sgn;
    logic [RED_W-1:0]  r_j;
    logic [PH_W-1:0]   r_kx;
    logic [PH_W-1:0]   r_ky;
    logic [PH_W-1:0]   r_kz;
    logic [PH_W-1:0]   r_py0;
    logic [PH_W-1:0]   r_pz0;
    logic [N_W-1:0]    r_cnt;

    logic [STEP_W-1:0]        mul_step;
    logic [DISP_W-1:0]        mul_disp;
    logic signed [PROD_W-1:0] prod;
    logic [MAG_W-1:0]         red_sub;
    logic [PH_W-1:0]          red_rem;
    logic [PH_W-1:0]          red_val;

    always_comb begin
        case (r_ax)
            2'd0: begin
                mul_step = r_step_gx;
                mul_disp = r_dx;
            end
            2'd1: begin
                mul_step = r_step_gy;
                mul_disp = r_dy;
            end
            default: begin
                mul_step = r_step_gz;
                mul_disp = r_dz;
            end
        endcase
        prod    = $signed({1'b0, mul_step}) * $signed(mul_disp);
        red_sub = MAG_W'(TWO_PI_Q32) << r_j;
        red_rem = r_mag[PH_W-1:0];
        red_val = (r_sgn && red_rem != '0) ? (TWO_PI_Q32 - red_rem) : red_rem;
    end

    // grid walk
    logic [N_W-1:0]   r_cx;
    logic [CNT_W-1:0] r_cy;
    logic [CNT_W-1:0] r_cz;
    logic [IDX_W-1:0] r_idx;
    logic [PH_W-1:0]  r_px;
    logic [PH_W-1:0]  r_pxy;
    logic [PH_W-1:0]  r_ph;

    logic [PH_W-1:0] add_a;
    logic [PH_W-1:0] add_b;
    logic [PH_W-1:0] add_s;

    // the one modular adder, shared by plane, row and point steps
    always_comb begin
        add_a = r_ph;
        add_b = r_kz;
        case (r_state)
            ST_PLANE: begin
                add_a = r_px;
                add_b = r_py0;
            end
            ST_ROW: begin
                add_a = r_pxy;
                add_b = r_pz0;
            end
            ST_EMIT: begin
                if (r_cz != side_m1) begin
                    add_a = r_ph;
                    add_b = r_kz;
                end else if (r_cy != side_m1) begin
                    add_a = r_pxy;
                    add_b = r_ky;
                end else begin
                    add_a = r_px;
                    add_b = r_kx;
                end
            end
            default: begin
                add_a = r_ph;
                add_b = r_kz;
            end
        endcase
        add_s = mod_add(add_a, add_b);
    end

    // cosine pipeline
    t_tag                      emit_tag;
    logic                      cord_vld;
    t_tag                      cord_tag;
    logic signed [TERM_W-1:0]  cord_term;
    logic                      cord_busy;

    assign emit_tag.idx = r_idx;
    assign emit_tag.dbl = (r_cx != '0);

    sfa_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_state == ST_EMIT),
        .i_phase (r_ph),
        .i_tag   (emit_tag),
        .o_vld   (cord_vld),
        .o_tag   (cord_tag),
        .o_term  (cord_term),
        .o_busy  (cord_busy)
    );

    // sum store and read-modify-write
    logic [SUM_W-1:0] r_mem [STORE_DEPTH];
    logic [SUM_W-1:0] r_rd;
    logic [IDX_W-1:0] mem_ra;
    logic [IDX_W-1:0] mem_wa;
    logic [SUM_W-1:0] mem_wd;
    logic             mem_we;

    logic                      r_w_vld;
    logic [IDX_W-1:0]          r_w_idx;
    logic signed [TERM_W-1:0]  r_w_term;
    logic [IDX_W-1:0]          r_clr_addr;
    logic signed [SUM_W:0]     sum_wide;
    logic [SUM_W-1:0]          sum_sat;

    always_comb begin
        sum_wide = $signed({r_rd[SUM_W-1], r_rd}) + (SUM_W+1)'(r_w_term);
        if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
            sum_sat = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                      : {1'b0, {(SUM_W-1){1'b1}}};
        end else begin
            sum_sat = sum_wide[SUM_W-1:0];
        end
        mem_ra = (r_state == ST_IDLE) ? i_req.point_index : cord_tag.idx;
        if (r_state == ST_CLR) begin
            mem_we = 1'b1;
            mem_wa = r_clr_addr;
            mem_wd = '0;
        end else begin
            mem_we = r_w_vld;
            mem_wa = r_w_idx;
            mem_wd = sum_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rd <= r_mem[mem_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_vld <= 1'b0;
        end else begin
            r_w_vld <= cord_vld;
        end
        r_w_idx  <= cord_tag.idx;
        r_w_term <= cord_term;
    end

    // read-back result register
    logic              r_o_vld;
    logic [IDX_W-1:0]  r_o_idx;
    logic [SUM_W-1:0]  r_o_sum;
    logic              r_rd_ok;

    assign o_rsp.valid      = r_o_vld;
    assign o_rsp.read_index = r_o_idx;
    assign o_rsp.phase_sum  = r_o_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (r_state == ST_RDOUT) begin
            r_o_vld <= 1'b1;
        end else if (o_rsp.ready) begin
            r_o_vld <= 1'b0;
        end
        if (r_state == ST_RDOUT) begin
            r_o_sum <= r_rd_ok ? r_rd : '0;
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLR;
            r_clr_addr <= '0;
        end else begin
            case (r_state)
                ST_CLR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (int'(r_clr_addr) == STORE_DEPTH - 1) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    r_clr_addr <= '0;
                    if (req_xfer) begin
                        case (t_req'(i_req.req_type))
                            REQ_ACC:   r_state <= ST_MUL;
                            REQ_READ:  r_state <= ST_RDOUT;
                            REQ_CLEAR: r_state <= ST_CLR;
                            default:   r_state <= ST_IDLE;
                        endcase
                    end
                end
                ST_RDOUT: r_state <= ST_IDLE;
                ST_MUL:   r_state <= ST_RED;
                ST_RED: begin
                    if (r_j == '0) begin
                        r_state <= ST_FIX;
                    end
                end
                ST_FIX: begin
                    if (r_ax == 2'd2) begin
                        r_state <= ST_NEG;
                    end else begin
                        r_state <= ST_MUL;
                    end
                end
                ST_NEG: begin
                    if (r_cnt == '0) begin
                        r_state <= ST_PLANE;
                    end
                end
                ST_PLANE: r_state <= ST_ROW;
                ST_ROW:   r_state <= ST_EMIT;
                ST_EMIT: begin
                    if (r_cz == side_m1) begin
                        if (r_cy != side_m1) begin
                            r_state <= ST_ROW;
                        end else if (r_cx != eff_n) begin
                            r_state <= ST_PLANE;
                        end else begin
                            r_state <= ST_DRAIN;
                        end
                    end
                end
                ST_DRAIN: begin
                    if (!cord_busy && !r_w_vld) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // datapath of the sequencer
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_dx    <= i_req.disp_x;
                r_dy    <= i_req.disp_y;
                r_dz    <= i_req.disp_z;
                // index held steady while an earlier result waits
                if (req_xfer) begin
                    r_o_idx <= i_req.point_index;
                end
                r_rd_ok <= ({1'b0, i_req.point_index} < grid_count(eff_n));
                r_ax    <= 2'd0;
                r_py0   <= '0;
                r_pz0   <= '0;
                r_cnt   <= eff_n;
            end
            ST_MUL: begin
                r_sgn <= prod[PROD_W-1];
                r_mag <= prod[PROD_W-1] ? MAG_W'(-prod) : prod[MAG_W-1:0];
                r_j   <= RED_W'(RED_TOP);
            end
            ST_RED: begin
                if (r_mag >= red_sub) begin
                    r_mag <= r_mag - red_sub;
                end
                r_j <= r_j - 1'b1;
            end
            ST_FIX: begin
                case (r_ax)
                    2'd0:    r_kx <= red_val;
                    2'd1:    r_ky <= red_val;
                    default: r_kz <= red_val;
                endcase
                r_ax <= r_ax + 1'b1;
            end
            ST_NEG: begin
                // start phases of the row and the column: -n*k mod 2*pi
                if (r_cnt != '0) begin
                    r_py0 <= mod_sub(r_py0, r_ky);
                    r_pz0 <= mod_sub(r_pz0, r_kz);
                    r_cnt <= r_cnt - 1'b1;
                end else begin
                    r_px  <= '0;
                    r_cx  <= '0;
                    r_idx <= plane_base(eff_n);
                end
            end
            ST_PLANE: begin
                r_pxy <= add_s;
                r_cy  <= '0;
            end
            ST_ROW: begin
                r_ph <= add_s;
                r_cz <= '0;
            end
            ST_EMIT: begin
                r_idx <= r_idx + 1'b1;
                if (r_cz != side_m1) begin
                    r_cz <= r_cz + 1'b1;
                    r_ph <= add_s;
                end else if (r_cy != side_m1) begin
                    r_cy  <= r_cy + 1'b1;
                    r_pxy <= add_s;
                end else if (r_cx != eff_n) begin
                    r_cx <= r_cx + 1'b1;
                    r_px <= add_s;
                end
            end
            default: r_cnt <= r_cnt;
        endcase
    end

endmodule
`default_nettype wire

[test/tb_structure_factor_accumulator_core.sv]
`timescale 1ns / 1ps
`default_nettype none
module tb_structure_factor_accumulator_core;
    import sfa_pkg::*;

    // generous bound; the slowest items are clears and n=7 accumulates
    localparam int CYCLE_LIMIT = 6_000_000;
    // idle time before a register write: longer than a clear or a full-size accumulate
    localparam int SETTLE_CYCLES = 4500;
    localparam int LONG_HOLD = 600;

    localparam longint TWO_PI_Q32_L = 64'd26986075409;
    localparam longint TWO_PI_Q16_L = 411775;
    localparam longint PI_Q16_L = 205887;
    localparam longint HALF_PI_Q16_L = 102944;
    localparam longint SAT_HI = 64'sd549755813887;
    localparam longint SAT_LO = -64'sd549755813888;

    typedef struct {
        t_req                     kind;
        logic signed [DISP_W-1:0] dx;
        logic signed [DISP_W-1:0] dy;
        logic signed [DISP_W-1:0] dz;
        logic [IDX_W-1:0]         idx;
    } t_item;

    typedef struct {
        logic [IDX_W-1:0] idx;
        logic [SUM_W-1:0] sum;
    } t_readback;

    // Shadow of the sum store plus the register set; predicts readbacks.
    class sum_tracker;
        longint    sums[STORE_DEPTH];
        int        half_reg;
        longint    gx, gy, gz;
        t_readback pending_reads[$];
        int        mismatches;

        function new();
            foreach (sums[i]) sums[i] = 0;
            half_reg = 1;
            gx = 65536;
            gy = 65536;
            gz = 65536;
            mismatches = 0;
        endfunction

        function int grid_n();
            return (half_reg < 1) ? 1 : ((half_reg > GRID_MAX) ? GRID_MAX : half_reg);
        endfunction

        function void set_reg(t_cfg which, longint v);
            case (which)
                CFG_GRID_HALF: half_reg = int'(v & 7);
                CFG_STEP_GX:   gx = v & 20'hFFFFF;
                CFG_STEP_GY:   gy = v & 20'hFFFFF;
                default:       gz = v & 20'hFFFFF;
            endcase
        endfunction

        // cosine in Q1.15 of a Q.32 phase, folded to the first quadrant
        function longint cosine_q15(longint phase);
            longint r, a, x, y, z, xs, ys;
            bit neg;
            r = phase % TWO_PI_Q32_L;
            if (r < 0) r += TWO_PI_Q32_L;
            a = r >>> 16;
            neg = 0;
            if (a > PI_Q16_L) a = TWO_PI_Q16_L - a;
            if (a > HALF_PI_Q16_L) begin
                a = PI_Q16_L - a;
                neg = 1;
            end
            x = 19899;
            y = 0;
            z = a;
            for (int i = 0; i < CORDIC_N; i++) begin
                xs = x >>> i;
                ys = y >>> i;
                if (z >= 0) begin
                    x -= ys;
                    y += xs;
                    z -= longint'(atan_q16(i));
                end else begin
                    x += ys;
                    y -= xs;
                    z += longint'(atan_q16(i));
                end
            end
            if (x < 0) x = 0;
            if (x > 32767) x = 32767;
            return neg ? -x : x;
        endfunction

        function void take_request(t_item it);
            int n, side, p;
            longint px, py, pz, w, s;
            t_readback rb;
            n = grid_n();
            side = 2 * n + 1;
            case (it.kind)
                REQ_ACC: begin
                    for (int ix = 0; ix <= n; ix++) begin
                        px = longint'(ix) * gx * longint'(it.dx);
                        w = (ix == 0) ? 1 : 2;
                        for (int iy = -n; iy <= n; iy++) begin
                            py = longint'(iy) * gy * longint'(it.dy);
                            for (int iz = -n; iz <= n; iz++) begin
                                pz = longint'(iz) * gz * longint'(it.dz);
                                p = ((ix + n) * side + (iy + n)) * side + (iz + n);
                                s = sums[p] + w * cosine_q15(px + py + pz);
                                if (s > SAT_HI) s = SAT_HI;
                                if (s < SAT_LO) s = SAT_LO;
                                sums[p] = s;
                            end
                        end
                    end
                end
                REQ_READ: begin
                    rb.idx = it.idx;
                    rb.sum = (int'(it.idx) < side * side * side) ? sums[it.idx][SUM_W-1:0] : '0;
                    pending_reads.push_back(rb);
                end
                REQ_CLEAR: foreach (sums[i]) sums[i] = 0;
                default: ;
            endcase
        endfunction

        function void match_readback(logic [IDX_W-1:0] idx, logic [SUM_W-1:0] sum);
            t_readback rb;
            if (pending_reads.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected readback idx=%0d sum=%0d", idx, $signed(sum));
                return;
            end
            rb = pending_reads.pop_front();
            if (rb.idx !== idx || rb.sum !== sum) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("readback mismatch: exp idx=%0d sum=%0d, got idx=%0d sum=%0d",
                             rb.idx, $signed(rb.sum), idx, $signed(sum));
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    sfa_req_if req_ch ();
    sfa_rsp_if rsp_ch ();

    structure_factor_accumulator_core DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_ch),
        .o_rsp      (rsp_ch)
    );

    sum_tracker tracker = new();
    int  cycles = 0;
    int  readbacks_seen = 0;
    bit  src_burst = 0;   // no gaps on the request side while set
    bit  dst_burst = 0;   // ready held high while set
    bit  long_hold_done = 0;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // timeout watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // result monitor: checks every readback transfer
    always @(posedge i_clk) begin
        if (rsp_ch.valid && rsp_ch.ready) begin
            tracker.match_readback(rsp_ch.read_index, rsp_ch.phase_sum);
            readbacks_seen <= readbacks_seen + 1;
        end
    end

    // readback side: random stalls, stall-free stretches, and one long hold-off
    // after a few dozen readbacks so that the request side backs up
    initial begin
        int gap;
        rsp_ch.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (!long_hold_done && readbacks_seen >= 30) begin
                long_hold_done = 1;
                gap = LONG_HOLD;
            end else begin
                gap = dst_burst ? 0 : $urandom_range(0, 11);
            end
            if (gap > 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!(rsp_ch.valid && rsp_ch.ready));
        end
    end

    // offer one request; returns just after the edge of its transfer
    task automatic send_item(t_item it);
        int gap;
        gap = src_burst ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.req_type    <= it.kind;
        req_ch.disp_x      <= it.dx;
        req_ch.disp_y      <= it.dy;
        req_ch.disp_z      <= it.dz;
        req_ch.point_index <= it.idx;
        do @(posedge i_clk); while (!(req_ch.valid && req_ch.ready));
        tracker.take_request(it);
    endtask

    // drain readbacks, let any accumulate or clear finish, then write registers
    task automatic apply_settings(int n, int sx, int sy, int sz);
        req_ch.valid <= 1'b0;
        while (tracker.pending_reads.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= CFG_GRID_HALF;
        i_cfg_data <= CFG_DATA_W'(n);
        @(posedge i_clk);
        i_cfg_idx <= CFG_STEP_GX;
        i_cfg_data <= CFG_DATA_W'(sx);
        @(posedge i_clk);
        i_cfg_idx <= CFG_STEP_GY;
        i_cfg_data <= CFG_DATA_W'(sy);
        @(posedge i_clk);
        i_cfg_idx <= CFG_STEP_GZ;
        i_cfg_data <= CFG_DATA_W'(sz);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        tracker.set_reg(CFG_GRID_HALF, n);
        tracker.set_reg(CFG_STEP_GX, sx);
        tracker.set_reg(CFG_STEP_GY, sy);
        tracker.set_reg(CFG_STEP_GZ, sz);
    endtask

    function automatic logic signed [DISP_W-1:0] draw_disp();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5) return DISP_W'($urandom);
        if (r < 8) return DISP_W'($signed($urandom_range(0, 131072)) - 65536);
        case ($urandom_range(0, 2))
            0:       return 24'sh7FFFFF;
            1:       return 24'sh800000;
            default: return 24'sh000000;
        endcase
    endfunction

    function automatic t_item make_item(int acc_pct);
        t_item it;
        int r, n, side, vol, base;
        n = tracker.grid_n();
        side = 2 * n + 1;
        vol = side * side * side;
        base = n * side * side;
        it.dx = draw_disp();
        it.dy = draw_disp();
        it.dz = draw_disp();
        r = $urandom_range(0, 99);
        if (r < acc_pct) it.kind = REQ_ACC;
        else if (r < acc_pct + 4) it.kind = REQ_CLEAR;
        else if (r < acc_pct + 9) it.kind = REQ_NONE;
        else it.kind = REQ_READ;
        // mostly the written half of the grid, some anywhere, some past the end
        r = $urandom_range(0, 99);
        if (r < 70) it.idx = IDX_W'($urandom_range(base, vol - 1));
        else if (r < 85) it.idx = IDX_W'($urandom_range(0, vol - 1));
        else it.idx = IDX_W'($urandom);
        return it;
    endfunction

    task automatic run_phase(int items, int acc_pct);
        for (int k = 0; k < items; k++) begin
            if (k % 20 == 0) begin
                src_burst = ($urandom_range(0, 3) == 0);
                dst_burst = ($urandom_range(0, 3) == 0);
            end
            send_item(make_item(acc_pct));
        end
    endtask

    function automatic t_item mk(t_req kind, int dx, int dy, int dz, int idx);
        t_item it;
        it.kind = kind;
        it.dx = DISP_W'(dx);
        it.dy = DISP_W'(dy);
        it.dz = DISP_W'(dz);
        it.idx = IDX_W'(idx);
        return it;
    endfunction

    initial begin
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= CFG_GRID_HALF;
        i_cfg_data <= '0;
        req_ch.valid <= 1'b0;
        req_ch.req_type <= REQ_NONE;
        req_ch.disp_x <= '0;
        req_ch.disp_y <= '0;
        req_ch.disp_z <= '0;
        req_ch.point_index <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed, default registers (n=1, unit steps): 27 points, written half 9..26
        send_item(mk(REQ_READ, 0, 0, 0, 13));
        send_item(mk(REQ_ACC, 0, 0, 0, 0));               // zero displacement: cos = 1
        send_item(mk(REQ_ACC, 8388607, 8388607, 8388607, 0));
        send_item(mk(REQ_ACC, -8388608, -8388608, -8388608, 0));
        send_item(mk(REQ_ACC, 65536, -65536, 32768, 0));
        send_item(mk(REQ_READ, 0, 0, 0, 0));              // ix<0 plane stays zero
        send_item(mk(REQ_READ, 0, 0, 0, 9));
        send_item(mk(REQ_READ, 0, 0, 0, 13));
        send_item(mk(REQ_READ, 0, 0, 0, 26));
        send_item(mk(REQ_READ, 0, 0, 0, 27));             // first index past the grid
        send_item(mk(REQ_READ, 0, 0, 0, 4095));
        send_item(mk(REQ_NONE, 1, 2, 3, 13));             // ignored request
        send_item(mk(REQ_READ, 0, 0, 0, 22));
        send_item(mk(REQ_CLEAR, 0, 0, 0, 0));
        send_item(mk(REQ_READ, 0, 0, 0, 22));
        send_item(mk(REQ_ACC, 102944, 0, 0, 0));           // phase near pi/2
        send_item(mk(REQ_ACC, 205887, 0, 0, 0));           // phase near pi
        send_item(mk(REQ_READ, 0, 0, 0, 22));
        send_item(mk(REQ_READ, 0, 0, 0, 14));

        run_phase(50, 30);
        // grid half 0 behaves as 1; smallest steps
        apply_settings(0, 1, 1, 1);
        run_phase(40, 35);
        // largest grid and steps: only a few long accumulates
        apply_settings(7, 1048575, 1048575, 1048575);
        run_phase(30, 10);
        // grid shrinks: old sums stay, reads use the new indexing
        apply_settings(2, $urandom_range(1, 1048575), $urandom_range(1, 1048575),
                       $urandom_range(1, 1048575));
        run_phase(45, 30);
        // zero step on one axis
        apply_settings(1, 0, $urandom_range(1, 1048575), 65536);
        run_phase(40, 35);
        apply_settings(3, $urandom_range(1, 1048575), $urandom_range(1, 1048575),
                       $urandom_range(1, 1048575));
        run_phase(40, 20);
        apply_settings(5, $urandom_range(1, 65536), $urandom_range(1, 65536),
                       $urandom_range(1, 65536));
        run_phase(25, 12);
        apply_settings(2, 1, 1048575, $urandom_range(1, 1048575));
        run_phase(45, 30);

        req_ch.valid <= 1'b0;
        while (tracker.pending_reads.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (tracker.mismatches == 0 && tracker.pending_reads.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
`default_nettype wire
